### rtl/core/b2ra_pkg.sv
// Package for the binary to radix ASCII unit: field widths, payload types,
// job classes and the digit to ASCII mapping. No dependencies.
package b2ra_pkg;

	localparam int VALUE_W          = 31;
	localparam int BASE_W           = 5;
	localparam int CHAR_W           = 8;
	localparam int DIGIT_W          = 4;
	localparam int COUNT_W          = 6;
	localparam int MAX_DIGITS       = 31;
	localparam int DIGIT_SLOTS_DFLT = 32;

	// divider: 32-bit dividend, four quotient bits per cycle
	localparam int DIV_W    = 32;
	localparam int DIV_STEP = 4;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;	// '0'
	localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h61;	// 'a'
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ZERO,
		KIND_BAD_BASE
	} kind_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		logic              error;
	} result_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_W-1:0]   quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		if (d < DIGIT_TEN)
			return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
		return CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DIGIT_TEN};
	endfunction

endpackage

### rtl/core/b2ra_stream_if.sv
// Valid/ready stream interface carrying one payload struct.
// Payload type is a parameter; types come from b2ra_pkg.
interface b2ra_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/b2ra_front.sv
// Front end: accepts requests, classifies them (bad base, zero, normal)
// and holds them in a two-entry queue for the back end. Uses b2ra_pkg.
module b2ra_front import b2ra_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	b2ra_stream_if.sink    item,
	b2ra_stream_if.source  job
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	job_t       new_job;
	logic       push;
	logic       pop;

	always_comb begin
		new_job.value = item.data.value;
		new_job.base  = item.data.base;
		if (item.data.base < BASE_MIN || item.data.base > BASE_MAX)
			new_job.kind = KIND_BAD_BASE;
		else if (item.data.value == '0)
			new_job.kind = KIND_ZERO;
		else
			new_job.kind = KIND_NORMAL;
	end

	assign item.ready = (fill_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign job.valid  = (fill_q != 2'd0);
	assign job.data   = entry_q[rd_ptr_q];
	assign pop        = job.valid && job.ready;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### rtl/core/b2ra_divider.sv
// Iterative divider: 32-bit dividend by a 5-bit base, four quotient bits
// per cycle. Uses b2ra_pkg.
module b2ra_divider import b2ra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int N_STEPS = DIV_W / DIV_STEP;
	localparam int STEP_W  = $clog2(N_STEPS);

	logic [DIV_W-1:0]  quo_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W-1:0]  quo_nx;
	logic [BASE_W-1:0] rem_nx;

	// restoring division, DIV_STEP bits; remainder stays below the divisor
	always_comb begin
		logic [BASE_W:0]  r;
		logic [DIV_W-1:0] w;
		r = {1'b0, rem_q};
		w = quo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[BASE_W-1:0], w[DIV_W-1]};
			w = {w[DIV_W-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r    = r - {1'b0, div_q};
				w[0] = 1'b1;
			end
		end
		quo_nx = w;
		rem_nx = r[BASE_W-1:0];
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				div_q  <= req.divisor;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q  <= quo_nx;
				rem_q  <= rem_nx;
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(N_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/b2ra_back.sv
// Back end: drives the divider, keeps remainders in the digit store and
// plays them back most significant first through an output register.
// Uses b2ra_pkg and b2ra_divider.
module b2ra_back import b2ra_pkg::*; #(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DFLT
) (
	input  logic           clk,
	input  logic           arst_n,
	b2ra_stream_if.sink    job,
	b2ra_stream_if.source  result
);

	localparam int IDX_W = $clog2(DIGIT_SLOTS);
	localparam int LIMIT = (DIGIT_SLOTS < MAX_DIGITS) ? DIGIT_SLOTS : MAX_DIGITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_SHOW
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] n_next;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [BASE_W-1:0]  base_q;
	logic               last_q;
	logic               err_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic [DIGIT_W-1:0] store [DIGIT_SLOTS];

	logic               job_take;
	logic               more;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [DIGIT_W-1:0] wr_data;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	b2ra_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		job.ready = (state_q == S_IDLE);
		job_take  = job.valid && job.ready;
		n_next    = n_q + 1'b1;
		more      = (div_rsp.quotient != '0) && (n_next < COUNT_W'(LIMIT));

		div_req.start = (job_take && job.data.kind == KIND_NORMAL) ||
		                (state_q == S_DIV && div_rsp.done && more);
		if (state_q == S_IDLE) begin
			div_req.dividend = {{(DIV_W-VALUE_W){1'b0}}, job.data.value};
			div_req.divisor  = job.data.base;
		end else begin
			div_req.dividend = div_rsp.quotient;
			div_req.divisor  = base_q;
		end

		// zero value: one '0' digit at slot 0
		if (state_q == S_IDLE) begin
			wr_en   = job_take && job.data.kind == KIND_ZERO;
			wr_idx  = '0;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == S_DIV) && div_rsp.done;
			wr_idx  = n_q[IDX_W-1:0];
			wr_data = div_rsp.remainder;
		end

		result.valid           = (state_q == S_SHOW);
		result.data.digit_char = err_q ? '0 : to_ascii(rd_data_q);
		result.data.last       = last_q;
		result.data.error      = err_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store[wr_idx] <= wr_data;
		if (state_q == S_READ)
			rd_data_q <= store[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			rd_idx_q <= '0;
			base_q   <= '0;
			last_q   <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_take) begin
						base_q <= job.data.base;
						n_q    <= '0;
						case (job.data.kind)
							KIND_BAD_BASE: begin
								err_q   <= 1'b1;
								last_q  <= 1'b1;
								state_q <= S_SHOW;
							end
							KIND_ZERO: begin
								err_q    <= 1'b0;
								rd_idx_q <= '0;
								state_q  <= S_READ;
							end
							default: begin
								err_q   <= 1'b0;
								state_q <= S_DIV;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (more) begin
							n_q <= n_next;
						end else begin
							rd_idx_q <= n_q[IDX_W-1:0];
							state_q  <= S_READ;
						end
					end
				end
				S_READ: begin
					last_q  <= (rd_idx_q == '0);
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (result.ready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/binary_to_radix_ascii_unit.sv
// Binary to radix ASCII converter, base 2..16, lower-case digits, MSD first.
// Flow: a bad base goes straight to its error result; otherwise each digit
// comes from the divider (8 four-bit steps), then each digit out is read
// from the store, then shown. The back end works on one request at a time.
// Reset: arst_n async low clears queue and sequencers; no clearing pass, the
// digit store is written before it is read in every conversion.
module binary_to_radix_ascii_unit import b2ra_pkg::*; #(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DFLT
) (
	input  logic           clk,
	input  logic           arst_n,
	b2ra_stream_if.sink    item,
	b2ra_stream_if.source  result
);

	// Classified requests wait here while the back end is busy, so a new
	// request can be taken while digits of the previous one are still out.
	b2ra_stream_if #(.payload_t(job_t)) job ();

	// Front: base check and zero detect, two-deep queue.
	b2ra_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.job    (job)
	);

	// Back: repeated division into the digit store, then reverse readout.
	// Conversions longer than the store keep only the lowest digits.
	b2ra_back #(
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.result (result)
	);

endmodule

### bench/tb_binary_to_radix_ascii_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for binary_to_radix_ascii_unit: directed digit cases, random
// traffic under several idling patterns and a long output hold-off.
// Depends on b2ra_pkg, b2ra_stream_if and the unit itself.
module tb_binary_to_radix_ascii_unit;
	import b2ra_pkg::*;

	// no-acceptance cycles before the run is declared hung; covers the slowest
	// request (31 digits) and the long hold-off
	localparam int STALL_LIMIT   = 20000;
	// quiet cycles after the last expected digit, covers a full 31-digit request
	localparam int DRAIN_CYCLES  = 400;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int SLOTS         = DIGIT_SLOTS_DFLT;
	localparam logic [CHAR_W-1:0] ASCII_ZERO   = "0";
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = "a";
	localparam logic [CHAR_W-1:0] ERROR_CHAR   = 8'h00;

	logic clk;
	logic arst_n;

	b2ra_stream_if #(.payload_t(item_t))   item_ch ();
	b2ra_stream_if #(.payload_t(result_t)) result_ch ();

	binary_to_radix_ascii_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// characters still owed by the unit, oldest first
	result_t pending_chars[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_left;		// cycles the receiver still refuses results
	int mismatch_count;
	int requests_sent;
	int bad_base_sent;
	int zero_value_sent;
	int digits_checked;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// --------------------------------------------------------------------
	// Predictor: repeated division by the base, remainders collected least
	// significant first and emitted in reverse as lower-case ASCII.
	// --------------------------------------------------------------------
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10)
			return ASCII_ZERO + CHAR_W'(d);
		return ASCII_LOWER_A + CHAR_W'(d - 4'd10);
	endfunction

	function automatic void predict_digits(input item_t req);
		int unsigned         v;
		int unsigned         b;
		int                  n;
		logic [DIGIT_W-1:0]  msd_first[$];
		result_t             r;
		v = req.value;
		b = req.base;
		n = 0;
		// invalid radix: one flagged result, no division at all
		if (b < BASE_MIN || b > BASE_MAX) begin
			r.digit_char = ERROR_CHAR;
			r.last       = 1'b1;
			r.error      = 1'b1;
			pending_chars.push_back(r);
			return;
		end
		// zero still yields one digit
		if (v == 0)
			msd_first.push_front('0);
		// higher digits beyond the store are dropped
		while (v != 0 && n < SLOTS && n < MAX_DIGITS) begin
			msd_first.push_front(DIGIT_W'(v % b));
			v = v / b;
			n++;
		end
		foreach (msd_first[i]) begin
			r.digit_char = digit_to_char(msd_first[i]);
			r.last       = (i == msd_first.size() - 1);
			r.error      = 1'b0;
			pending_chars.push_back(r);
		end
	endfunction

	// --------------------------------------------------------------------
	// Request side. Valid stays high across back-to-back requests; it is
	// lowered only when the sender decides to idle.
	// --------------------------------------------------------------------
	task automatic send_request(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
		item_t req;
		req.value = value;
		req.base  = base;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= req;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		// accepted at this edge; the unit cannot answer before the next one
		predict_digits(req);
		requests_sent++;
		if (base < BASE_MIN || base > BASE_MAX)
			bad_base_sent++;
		else if (value == 0)
			zero_value_sent++;
	endtask

	function automatic item_t random_request();
		item_t req;
		int    width;
		int    pick;
		// spread value sizes so short and long conversions both show up
		width = $urandom_range(0, VALUE_W);
		if (width == 0)
			req.value = '0;
		else if ($urandom_range(0, 7) == 0)
			req.value = VALUE_W'((64'd1 << width) - 1);
		else
			req.value = VALUE_W'($urandom & ((64'd1 << width) - 1));
		// about one in ten with an invalid radix: 0, 1 or 17..31
		if ($urandom_range(0, 9) == 0) begin
			pick     = $urandom_range(0, 16);
			req.base = BASE_W'((pick < 2) ? pick : pick + 15);
		end else begin
			req.base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
		end
		return req;
	endfunction

	// --------------------------------------------------------------------
	// Result side: check every accepted digit, then pick next ready.
	// --------------------------------------------------------------------
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_ch.valid && result_ch.ready) begin
					if (pending_chars.size() == 0) begin
						$error("unexpected result: digit_char 0x%02h last %0b error %0b",
							result_ch.data.digit_char, result_ch.data.last,
							result_ch.data.error);
						mismatch_count++;
					end else begin
						result_t want;
						want = pending_chars.pop_front();
						digits_checked++;
						if (result_ch.data.digit_char !== want.digit_char) begin
							$error("digit_char mismatch: expected 0x%02h, got 0x%02h",
								want.digit_char, result_ch.data.digit_char);
							mismatch_count++;
						end
						if (result_ch.data.last !== want.last) begin
							$error("last mismatch: expected %0b, got %0b",
								want.last, result_ch.data.last);
							mismatch_count++;
						end
						if (result_ch.data.error !== want.error) begin
							$error("error mismatch: expected %0b, got %0b",
								want.error, result_ch.data.error);
							mismatch_count++;
						end
					end
				end
				// long hold-off wins over random stalls
				if (hold_left > 0) begin
					result_ch.ready <= 1'b0;
					hold_left--;
				end else begin
					result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
				end
			end
		end
	end

	// watchdog: any acceptance on either side counts as progress
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no request or digit accepted for %0d cycles", STALL_LIMIT);
				$display("binary_to_radix_ascii_unit test failed");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------
	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// field extremes, zero value, letter digits and invalid radixes
	task automatic test_directed_cases();
		set_idling(0, 0);
		send_request(31'd0, 5'd10);
		send_request(31'd0, 5'd2);
		send_request(31'd0, 5'd16);
		send_request(31'h7FFFFFFF, 5'd2);	// longest conversion, 31 digits
		send_request(31'h7FFFFFFF, 5'd3);
		send_request(31'h7FFFFFFF, 5'd10);
		send_request(31'h7FFFFFFF, 5'd16);
		send_request(31'd1, 5'd2);
		send_request(31'd1, 5'd16);
		send_request(31'd13, 5'd16);		// 'd'
		send_request(31'd14, 5'd16);		// 'e'
		send_request(31'd15, 5'd16);		// 'f'
		send_request(31'hDEF, 5'd16);
		send_request(31'h7EDCBA98, 5'd16);
		send_request(31'h01234567, 5'd16);
		send_request(31'd16, 5'd16);
		send_request(31'd10, 5'd10);
		send_request(31'd12, 5'd13);
		send_request(31'd224, 5'd15);
		send_request(31'd0, 5'd0);			// invalid radixes
		send_request(31'h7FFFFFFF, 5'd1);
		send_request(31'd5, 5'd17);
		send_request(31'h2AAAAAAA, 5'd31);
		send_request(31'h55555555, 5'd0);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
		input int count);
		item_t req;
		set_idling(sender_pct, receiver_pct);
		repeat (count) begin
			req = random_request();
			send_request(req.value, req.base);
		end
	endtask

	// receiver refuses for a long stretch while requests keep coming, so the
	// unit's buffering fills and its input stalls
	task automatic test_output_hold_off();
		item_t req;
		set_idling(0, 0);
		hold_left = HOLD_OFF_LEN;
		repeat (16) begin
			req = random_request();
			send_request(req.value, req.base);
		end
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		arst_n        <= 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_left          = 0;
		mismatch_count     = 0;
		requests_sent      = 0;
		bad_base_sent      = 0;
		zero_value_sent    = 0;
		digits_checked     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(0, 0, 105);
		test_random_traffic(77, 0, 105);
		test_random_traffic(0, 77, 105);
		test_random_traffic(29, 29, 105);
		test_output_hold_off();
		test_random_traffic(0, 0, 20);

		// stop offering, let the owed digits arrive, then watch for extras
		item_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			$error("%0d expected digits never arrived", pending_chars.size());
			mismatch_count++;
		end

		$display("Covered %0d requests (%0d invalid radix, %0d zero values), %0d digits checked,",
			requests_sent, bad_base_sent, zero_value_sent, digits_checked);
		$display("under free flow, sender gaps, receiver stalls, both, and a long hold-off.");
		if (mismatch_count == 0) begin
			$display("binary_to_radix_ascii_unit test passed");
		end else begin
			$display("binary_to_radix_ascii_unit test failed");
		end
		$finish;
	end

endmodule
